### hdl/ecd_pkg.sv
// shared widths and constants for the epoch milliseconds to civil date unit
`default_nettype none

package ecd_pkg;

   // request and response field widths
   localparam int unsigned EPOCH_MS_W = 64;
   localparam int unsigned YEAR_W     = 29;
   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned DAY_W      = 5;

   // milliseconds per day split as 2^10 * 84375
   localparam int unsigned MS_DAY_SHIFT = 10;
   localparam int unsigned DAY_DIVISOR  = 84375;
   localparam int unsigned DAY_NUM_W    = EPOCH_MS_W - 1 - MS_DAY_SHIFT;
   localparam int unsigned DAY_CHUNK_W  = 15;
   localparam int unsigned DAY_REM_W    = $clog2(DAY_DIVISOR);
   localparam int unsigned DAY_TOP_W    = DAY_NUM_W - 3 * DAY_CHUNK_W;

   // day count and 400-year era split
   localparam int unsigned DAYS_W       = 37;
   localparam int unsigned EPOCH_SHIFT  = 719468;
   localparam int unsigned DAYS_PER_ERA = 146097;
   localparam int unsigned ERA_CHUNK_W  = 14;
   localparam int unsigned ERA_REM_W    = $clog2(DAYS_PER_ERA);
   localparam int unsigned ERA_TOP_W    = DAYS_W - 2 * ERA_CHUNK_W;
   localparam int unsigned ERA_W        = 20;

   // day of era, year of era, day of year, march-based month
   localparam int unsigned DOE_W = ERA_REM_W;
   localparam int unsigned YOE_W = 9;
   localparam int unsigned DOY_W = 9;
   localparam int unsigned MP_W  = 4;

endpackage

`default_nettype wire

### hdl/ecd_req_if.sv
// request channel: one signed millisecond timestamp per transfer
`default_nettype none

interface ecd_req_if;
   import ecd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [EPOCH_MS_W-1:0] unix_ms;

   modport source (output valid, output unix_ms, input ready);
   modport sink (input valid, input unix_ms, output ready);
endinterface

`default_nettype wire

### hdl/ecd_rsp_if.sv
// response channel: error flag and numeric calendar date
`default_nettype none

interface ecd_rsp_if;
   import ecd_pkg::*;

   logic               valid;
   logic               ready;
   logic               bad_time;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day_of_month;

   modport source (output valid, output bad_time, output year, output month,
                   output day_of_month, input ready);
   modport sink (input valid, input bad_time, input year, input month,
                 input day_of_month, output ready);
endinterface

`default_nettype wire

### hdl/ecd_div_step.sv
// two-stage long-division digit by a constant divisor using a reciprocal estimate
`default_nettype none

module ecd_div_step #(
   parameter int unsigned DIVISOR = ecd_pkg::DAY_DIVISOR,
   parameter int unsigned CHUNK_W = ecd_pkg::DAY_CHUNK_W
) (
   input  wire logic                         clock,
   input  wire logic                         en_a,
   input  wire logic                         en_b,
   input  wire logic [$clog2(DIVISOR)-1:0]   prev_rem,
   input  wire logic [CHUNK_W-1:0]           chunk,
   output logic      [CHUNK_W-1:0]           quot,
   output logic      [$clog2(DIVISOR)-1:0]   rem
);

   localparam int unsigned REM_W = $clog2(DIVISOR);
   localparam int unsigned N_W   = REM_W + CHUNK_W;
   localparam int unsigned M_W   = CHUNK_W + 1;
   localparam int unsigned P_W   = N_W + M_W;
   localparam longint unsigned RecipFull = (64'd1 << N_W) / DIVISOR;
   localparam logic [M_W-1:0]   RECIP = M_W'(RecipFull);
   localparam logic [REM_W:0]   DIV_C = (REM_W + 1)'(DIVISOR);

   logic [N_W-1:0]     num_in;
   logic [P_W-1:0]     prod_a;
   logic [CHUNK_W-1:0] qe_in;
   logic [N_W-1:0]     num_ff;
   logic [CHUNK_W-1:0] qe_ff;
   logic [N_W-1:0]     prod_b;
   logic [N_W-1:0]     diff;
   logic [REM_W:0]     diff_low;
   logic               fix;
   logic [CHUNK_W-1:0] quot_in;
   logic [REM_W-1:0]   rem_in;
   logic [CHUNK_W-1:0] quot_ff;
   logic [REM_W-1:0]   rem_ff;

   // estimate, low by at most one
   assign num_in = {prev_rem, chunk};
   assign prod_a = P_W'(num_in) * P_W'(RECIP);
   assign qe_in  = prod_a[N_W +: CHUNK_W];

   always_ff @(posedge clock) begin
      if (en_a) begin
         num_ff <= num_in;
         qe_ff  <= qe_in;
      end
   end

   // remainder and single correction
   assign prod_b   = N_W'(qe_ff) * N_W'(DIVISOR);
   assign diff     = num_ff - prod_b;
   assign diff_low = diff[REM_W:0];
   assign fix      = (diff_low >= DIV_C);
   assign quot_in  = qe_ff + CHUNK_W'(fix);
   assign rem_in   = fix ? REM_W'(diff_low - DIV_C) : diff_low[REM_W-1:0];

   always_ff @(posedge clock) begin
      if (en_b) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

### hdl/epoch_ms_to_civil_date_unit.sv
// epoch milliseconds to proleptic gregorian utc date, fully pipelined
//
// req_ch carries one signed 64-bit millisecond count per request; rsp_ch
// returns bad_time, year, month and day_of_month for it, in request order.
// both channels transfer when valid and ready are high at a rising edge.
// a negative count gives bad_time = 1 with all date fields zero.
// the result is loaded into the output register at the end of the pipeline
// and is offered on rsp_ch from there until it is taken.
// throughput: one request per cycle while rsp_ch is ready; the 17 pipeline
// stages are set by the two long divisions (three digit steps for days, two
// for eras, two stages per digit) and the short year/month/day arithmetic after them.
// each stage moves when the stage after it is empty or moving, so a stall
// on rsp_ch first fills the empty stages and only then drops req_ch.ready.
// synchronous reset empties the pipeline; nothing else needs clearing.
`default_nettype none

module epoch_ms_to_civil_date_unit (
   input wire logic   clock,
   input wire logic   reset,
   ecd_req_if.sink    req_ch,
   ecd_rsp_if.source  rsp_ch
);

   import ecd_pkg::*;

   localparam int unsigned LAST = 16;

   // exact reciprocal constants for the narrow divisions
   localparam int unsigned Q1460_SHIFT  = 29;
   localparam int unsigned Q36524_SHIFT = 34;
   localparam int unsigned Q365_SHIFT   = 27;
   localparam int unsigned Q100_SHIFT   = 16;
   localparam int unsigned Q153_SHIFT   = 19;
   localparam logic [18:0] Q1460_MULT =
      19'(((64'd1 << Q1460_SHIFT) + 64'd1460 - 64'd1) / 64'd1460);
   localparam logic [18:0] Q36524_MULT =
      19'(((64'd1 << Q36524_SHIFT) + 64'd36524 - 64'd1) / 64'd36524);
   localparam logic [18:0] Q365_MULT =
      19'(((64'd1 << Q365_SHIFT) + 64'd365 - 64'd1) / 64'd365);
   localparam logic [9:0]  Q100_MULT =
      10'(((64'd1 << Q100_SHIFT) + 64'd100 - 64'd1) / 64'd100);
   localparam longint unsigned Q153Full =
      ((64'd1 << Q153_SHIFT) + 64'd153 - 64'd1) / 64'd153;
   localparam logic [23:0] MP_MULT = 24'(5 * Q153Full);
   localparam logic [23:0] MP_ADD  = 24'(2 * Q153Full);

   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] ofs;
      case (mp)
         4'd0:    ofs = 9'd0;
         4'd1:    ofs = 9'd31;
         4'd2:    ofs = 9'd61;
         4'd3:    ofs = 9'd92;
         4'd4:    ofs = 9'd122;
         4'd5:    ofs = 9'd153;
         4'd6:    ofs = 9'd184;
         4'd7:    ofs = 9'd214;
         4'd8:    ofs = 9'd245;
         4'd9:    ofs = 9'd275;
         4'd10:   ofs = 9'd306;
         4'd11:   ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

   // pipeline control
   logic [LAST:0]   vld_ff;
   logic [LAST+1:0] en;
   logic [LAST-1:0] bad_ff;

   assign en[LAST+1] = rsp_ch.ready;
   for (genvar k = 0; k <= LAST; k++) begin : g_en
      assign en[k] = ~vld_ff[k] | en[k+1];
   end

   assign req_ch.ready = en[0] & ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_ch.valid;
         for (int k = 1; k <= LAST; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) bad_ff[0] <= req_ch.unix_ms[EPOCH_MS_W-1];
      for (int k = 1; k < LAST; k++) begin
         if (en[k]) bad_ff[k] <= bad_ff[k-1];
      end
   end

   // input register: milliseconds with the power-of-two part of a day removed
   logic [DAY_NUM_W-1:0] num0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) num0_ff <= req_ch.unix_ms[EPOCH_MS_W-2 -: DAY_NUM_W];
   end

   // whole days: three digit steps by 84375
   logic [2*DAY_CHUNK_W-1:0] lo_s1_ff, lo_s2_ff;
   logic [DAY_CHUNK_W-1:0]   lo_s3_ff, lo_s4_ff;
   logic [DAY_CHUNK_W-1:0]   q1_s3_ff, q1_s4_ff, q1_s5_ff, q1_s6_ff;
   logic [DAY_CHUNK_W-1:0]   q2_s5_ff, q2_s6_ff;
   logic [DAY_CHUNK_W-1:0]   d1_quot, d2_quot, d3_quot;
   logic [DAY_REM_W-1:0]     d1_rem, d2_rem, d3_rem;

   ecd_div_step #(
      .DIVISOR (DAY_DIVISOR),
      .CHUNK_W (DAY_CHUNK_W)
   ) u_day_step1 (
      .clock    (clock),
      .en_a     (en[1]),
      .en_b     (en[2]),
      .prev_rem (DAY_REM_W'(num0_ff[DAY_NUM_W-1 -: DAY_TOP_W])),
      .chunk    (num0_ff[3*DAY_CHUNK_W-1 -: DAY_CHUNK_W]),
      .quot     (d1_quot),
      .rem      (d1_rem)
   );

   ecd_div_step #(
      .DIVISOR (DAY_DIVISOR),
      .CHUNK_W (DAY_CHUNK_W)
   ) u_day_step2 (
      .clock    (clock),
      .en_a     (en[3]),
      .en_b     (en[4]),
      .prev_rem (d1_rem),
      .chunk    (lo_s2_ff[2*DAY_CHUNK_W-1 -: DAY_CHUNK_W]),
      .quot     (d2_quot),
      .rem      (d2_rem)
   );

   ecd_div_step #(
      .DIVISOR (DAY_DIVISOR),
      .CHUNK_W (DAY_CHUNK_W)
   ) u_day_step3 (
      .clock    (clock),
      .en_a     (en[5]),
      .en_b     (en[6]),
      .prev_rem (d2_rem),
      .chunk    (lo_s4_ff),
      .quot     (d3_quot),
      .rem      (d3_rem)
   );

   always_ff @(posedge clock) begin
      if (en[1]) lo_s1_ff <= num0_ff[2*DAY_CHUNK_W-1:0];
      if (en[2]) lo_s2_ff <= lo_s1_ff;
      if (en[3]) begin
         lo_s3_ff <= lo_s2_ff[DAY_CHUNK_W-1:0];
         q1_s3_ff <= d1_quot;
      end
      if (en[4]) begin
         lo_s4_ff <= lo_s3_ff;
         q1_s4_ff <= q1_s3_ff;
      end
      if (en[5]) begin
         q1_s5_ff <= q1_s4_ff;
         q2_s5_ff <= d2_quot;
      end
      if (en[6]) begin
         q1_s6_ff <= q1_s5_ff;
         q2_s6_ff <= q2_s5_ff;
      end
   end

   // day number from 0000-03-01
   logic [3*DAY_CHUNK_W-1:0] days_all;
   logic [DAYS_W-1:0]        z_in;
   logic [DAYS_W-1:0]        z_ff;
   logic                     d3_rem_unused;

   assign days_all      = {q1_s6_ff, q2_s6_ff, d3_quot};
   assign z_in          = days_all[DAYS_W-1:0] + DAYS_W'(EPOCH_SHIFT);
   assign d3_rem_unused = ^d3_rem;

   always_ff @(posedge clock) begin
      if (en[7]) z_ff <= z_in;
   end

   // era and day of era: two digit steps by 146097
   logic [ERA_CHUNK_W-1:0] zlo_s8_ff, zlo_s9_ff;
   logic [ERA_CHUNK_W-1:0] q4_s10_ff, q4_s11_ff;
   logic [ERA_CHUNK_W-1:0] e1_quot, e2_quot;
   logic [ERA_REM_W-1:0]   e1_rem, e2_rem;

   ecd_div_step #(
      .DIVISOR (DAYS_PER_ERA),
      .CHUNK_W (ERA_CHUNK_W)
   ) u_era_step1 (
      .clock    (clock),
      .en_a     (en[8]),
      .en_b     (en[9]),
      .prev_rem (ERA_REM_W'(z_ff[DAYS_W-1 -: ERA_TOP_W])),
      .chunk    (z_ff[2*ERA_CHUNK_W-1 -: ERA_CHUNK_W]),
      .quot     (e1_quot),
      .rem      (e1_rem)
   );

   ecd_div_step #(
      .DIVISOR (DAYS_PER_ERA),
      .CHUNK_W (ERA_CHUNK_W)
   ) u_era_step2 (
      .clock    (clock),
      .en_a     (en[10]),
      .en_b     (en[11]),
      .prev_rem (e1_rem),
      .chunk    (zlo_s9_ff),
      .quot     (e2_quot),
      .rem      (e2_rem)
   );

   always_ff @(posedge clock) begin
      if (en[8]) zlo_s8_ff <= z_ff[ERA_CHUNK_W-1:0];
      if (en[9]) zlo_s9_ff <= zlo_s8_ff;
      if (en[10]) q4_s10_ff <= e1_quot;
      if (en[11]) q4_s11_ff <= q4_s10_ff;
   end

   // stage 12: leap-corrected day of era, era scaled to years
   logic [2*ERA_CHUNK_W-1:0] era_all;
   logic [ERA_W-1:0]         era;
   logic [36:0]              p1460, p36524;
   logic [DOE_W-1:0]         n1460, n36524, n_last;
   logic [DOE_W-1:0]         t_in;
   logic [YEAR_W-1:0]        era400_in;
   logic [DOE_W-1:0]         t_ff, doe12_ff;
   logic [YEAR_W-1:0]        era400_12_ff;

   assign era_all   = {q4_s11_ff, e2_quot};
   assign era       = era_all[ERA_W-1:0];
   assign p1460     = 37'(e2_rem) * 37'(Q1460_MULT);
   assign p36524    = 37'(e2_rem) * 37'(Q36524_MULT);
   assign n1460     = DOE_W'(p1460[Q1460_SHIFT +: 7]);
   assign n36524    = DOE_W'(p36524[Q36524_SHIFT +: 3]);
   assign n_last    = DOE_W'(e2_rem == DOE_W'(DAYS_PER_ERA - 1));
   assign t_in      = e2_rem - n1460 + n36524 - n_last;
   assign era400_in = YEAR_W'({era, 8'b0}) + YEAR_W'({era, 7'b0})
                    + YEAR_W'({era, 4'b0});

   always_ff @(posedge clock) begin
      if (en[12]) begin
         t_ff         <= t_in;
         doe12_ff     <= e2_rem;
         era400_12_ff <= era400_in;
      end
   end

   // stage 13: year of era
   logic [36:0]       p365;
   logic [YOE_W-1:0]  yoe_in;
   logic [YOE_W-1:0]  yoe13_ff;
   logic [DOE_W-1:0]  doe13_ff;
   logic [YEAR_W-1:0] era400_13_ff;

   assign p365   = 37'(t_ff) * 37'(Q365_MULT);
   assign yoe_in = p365[Q365_SHIFT +: YOE_W];

   always_ff @(posedge clock) begin
      if (en[13]) begin
         yoe13_ff     <= yoe_in;
         doe13_ff     <= doe12_ff;
         era400_13_ff <= era400_12_ff;
      end
   end

   // stage 14: day of year
   logic [18:0]       p100;
   logic [DOE_W-1:0]  yr_days;
   logic [DOE_W-1:0]  doy_full;
   logic [DOY_W-1:0]  doy_in;
   logic [DOY_W-1:0]  doy14_ff;
   logic [YOE_W-1:0]  yoe14_ff;
   logic [YEAR_W-1:0] era400_14_ff;

   assign p100     = 19'(yoe13_ff) * 19'(Q100_MULT);
   assign yr_days  = DOE_W'(yoe13_ff) * DOE_W'(365) + DOE_W'(yoe13_ff >> 2)
                   - DOE_W'(p100[Q100_SHIFT +: 2]);
   assign doy_full = doe13_ff - yr_days;
   assign doy_in   = doy_full[DOY_W-1:0];

   always_ff @(posedge clock) begin
      if (en[14]) begin
         doy14_ff     <= doy_in;
         yoe14_ff     <= yoe13_ff;
         era400_14_ff <= era400_13_ff;
      end
   end

   // stage 15: march-based month
   logic [23:0]       pmp;
   logic [MP_W-1:0]   mp_in;
   logic [MP_W-1:0]   mp15_ff;
   logic [DOY_W-1:0]  doy15_ff;
   logic [YOE_W-1:0]  yoe15_ff;
   logic [YEAR_W-1:0] era400_15_ff;

   assign pmp   = 24'(doy14_ff) * MP_MULT + MP_ADD;
   assign mp_in = pmp[Q153_SHIFT +: MP_W];

   always_ff @(posedge clock) begin
      if (en[15]) begin
         mp15_ff      <= mp_in;
         doy15_ff     <= doy14_ff;
         yoe15_ff     <= yoe14_ff;
         era400_15_ff <= era400_14_ff;
      end
   end

   // stage 16: output register
   logic [DOY_W-1:0]   dom_full;
   logic [MONTH_W-1:0] month_in;
   logic [YEAR_W-1:0]  year_in;
   logic               rsp_bad_ff;
   logic [YEAR_W-1:0]  rsp_year_ff;
   logic [MONTH_W-1:0] rsp_month_ff;
   logic [DAY_W-1:0]   rsp_day_ff;

   assign dom_full = doy15_ff - month_start(mp15_ff) + DOY_W'(1);
   assign month_in = (mp15_ff < MP_W'(10)) ? MONTH_W'(mp15_ff + MP_W'(3))
                                           : MONTH_W'(mp15_ff - MP_W'(9));
   assign year_in  = era400_15_ff + YEAR_W'(yoe15_ff)
                   + YEAR_W'(month_in <= MONTH_W'(2));

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         rsp_bad_ff <= bad_ff[LAST-1];
         if (bad_ff[LAST-1]) begin
            rsp_year_ff  <= '0;
            rsp_month_ff <= '0;
            rsp_day_ff   <= '0;
         end else begin
            rsp_year_ff  <= year_in;
            rsp_month_ff <= month_in;
            rsp_day_ff   <= dom_full[DAY_W-1:0];
         end
      end
   end

   assign rsp_ch.valid        = vld_ff[LAST];
   assign rsp_ch.bad_time     = rsp_bad_ff & ~d3_rem_unused | rsp_bad_ff;
   assign rsp_ch.year         = rsp_year_ff;
   assign rsp_ch.month        = rsp_month_ff;
   assign rsp_ch.day_of_month = rsp_day_ff;

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for the epoch milliseconds to civil date unit: directed and random timestamps
`timescale 1ns / 100ps

module tb;
   import ecd_pkg::*;

   localparam longint unsigned MS_PER_DAY   = 64'd86400000;
   localparam longint unsigned MAX_DAY      = 64'h7fff_ffff_ffff_ffff / MS_PER_DAY;
   localparam int              RANDOM_ITEMS = 800;
   localparam int              HOLD_CYCLES  = 80;

   typedef struct {
      logic               bad_time;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day_of_month;
   } civil_date_type;

   logic clock;
   logic reset;

   ecd_req_if req_if ();
   ecd_rsp_if rsp_if ();

   epoch_ms_to_civil_date_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   logic [63:0]    stamp_queue[$];
   civil_date_type date_due[$];
   civil_date_type date_head;
   logic           req_taken;
   int             stamps_taken;
   int             negatives_taken;
   int             dates_seen;
   int             date_errors;
   int             hold_left;
   bit             hold_done;

   // unsigned civil-from-days on whole days since a march-based day zero
   function automatic civil_date_type civil_date_of(logic [63:0] stamp);
      bit [63:0]      days, z, era, doe, yoe, doy, mp, yr, mon, dom;
      civil_date_type r;
      r.bad_time     = 1'b0;
      r.year         = '0;
      r.month        = '0;
      r.day_of_month = '0;
      if (stamp[63]) begin
         r.bad_time = 1'b1;
         return r;
      end
      days = stamp / MS_PER_DAY;
      z    = days + EPOCH_SHIFT;
      era  = z / DAYS_PER_ERA;
      doe  = z - era * DAYS_PER_ERA;
      yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr   = yoe + era * 400;
      doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp   = (5 * doy + 2) / 153;
      dom  = doy - (153 * mp + 2) / 5 + 1;
      mon  = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2)
         yr = yr + 1;
      r.year         = yr[YEAR_W-1:0];
      r.month        = mon[MONTH_W-1:0];
      r.day_of_month = dom[DAY_W-1:0];
      return r;
   endfunction

   task automatic queue_stamp(input logic [63:0] s);
      stamp_queue.insert(stamp_queue.size(), s);
   endtask

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.unix_ms <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (stamp_queue.size() > 0 &&
             ((stamps_taken >= 400 && stamps_taken < 550) ||
              $urandom_range(0, 99) >= 25)) begin
            req_if.valid   <= 1'b1;
            req_if.unix_ms <= stamp_queue.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back the pipeline up
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (dates_seen >= 120 && !hold_done) begin
         hold_left    <= HOLD_CYCLES - 1;
         hold_done    <= 1'b1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (dates_seen >= 400 && dates_seen < 550) ||
                         ($urandom_range(0, 99) >= 25);
      end
   end

   // request capture and response check
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
            dates_seen++;
            if (date_due.size() == 0) begin
               $error("response with no request outstanding");
               date_errors++;
            end else begin
               date_head = date_due.pop_front();
               if (rsp_if.bad_time !== date_head.bad_time) begin
                  $error("bad_time: expected %0d, got %0d",
                         date_head.bad_time, rsp_if.bad_time);
                  date_errors++;
               end
               if (rsp_if.year !== date_head.year) begin
                  $error("year: expected %0d, got %0d", date_head.year, rsp_if.year);
                  date_errors++;
               end
               if (rsp_if.month !== date_head.month) begin
                  $error("month: expected %0d, got %0d", date_head.month, rsp_if.month);
                  date_errors++;
               end
               if (rsp_if.day_of_month !== date_head.day_of_month) begin
                  $error("day_of_month: expected %0d, got %0d",
                         date_head.day_of_month, rsp_if.day_of_month);
                  date_errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            date_due.insert(date_due.size(), civil_date_of(req_if.unix_ms));
            stamps_taken++;
            if (req_if.unix_ms[63])
               negatives_taken++;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] stamp;
      logic [63:0] days;
      logic [63:0] z;
      int          total;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.unix_ms  = '0;
      rsp_if.ready    = 1'b0;
      stamps_taken    = 0;
      negatives_taken = 0;
      dates_seen      = 0;
      date_errors     = 0;

      // epoch, day edges, leap days, century and era edges, extremes
      queue_stamp(64'd0);
      queue_stamp(64'd86399999);
      queue_stamp(64'd86400000);
      queue_stamp(64'd5097600000);
      queue_stamp(64'd31449600000);
      queue_stamp(64'd31536000000);
      queue_stamp(64'd68169600000);
      queue_stamp(64'd946684799999);
      queue_stamp(64'd946684800000);
      queue_stamp(64'd951782400000);
      queue_stamp(64'd951868799999);
      queue_stamp(64'd951868800000);
      queue_stamp(64'd2147483647000);
      queue_stamp(64'd4107542399999);
      queue_stamp(64'd4107542400000);
      queue_stamp(64'd13574649599999);
      queue_stamp(64'd13574649600000);
      queue_stamp(64'h4000_0000_0000_0000);
      queue_stamp(64'h7fff_ffff_ffff_ffff);
      queue_stamp(MAX_DAY * MS_PER_DAY);
      queue_stamp(64'hffff_ffff_ffff_ffff);
      queue_stamp(-64'sd86400000);
      queue_stamp(64'h8000_0000_0000_0000);
      queue_stamp(64'h8000_0000_0000_0001);

      repeat (RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: stamp = {$urandom, $urandom};
            1: stamp = {1'b1, 31'($urandom), $urandom};
            2: stamp = {22'd0, 10'($urandom_range(0, 1023)), $urandom};
            3: begin
               days = {27'd0, 5'($urandom), $urandom} % MAX_DAY;
               case ($urandom_range(0, 2))
                  0: stamp = days * MS_PER_DAY;
                  1: stamp = days * MS_PER_DAY + MS_PER_DAY - 1;
                  default: stamp = days * MS_PER_DAY + $urandom_range(0, 86399999);
               endcase
            end
            default: begin
               // near the start of an era or of a century inside it
               z = 64'($urandom_range(5, 730000)) * DAYS_PER_ERA +
                   64'd36524 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2;
               days  = z - EPOCH_SHIFT;
               stamp = days * MS_PER_DAY + $urandom_range(0, 86399999);
            end
         endcase
         queue_stamp(stamp);
      end
      total = stamp_queue.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stamps_taken < total || date_due.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("converted %0d timestamps, %0d negative, including leap days and era edges",
               stamps_taken, negatives_taken);
      $display("checked %0d dates with %0d field mismatches", dates_seen, date_errors);
      if (date_errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d dates still outstanding", date_due.size());
      $display("tb NOT OK");
      $finish;
   end

endmodule
